[rtl/fprc_pkg.sv]
// ----------------------------------------------------------------------------
// Framed packet receiver package
// Types and constants shared by the receiver's interfaces and modules.
// ----------------------------------------------------------------------------
package fprc_pkg;

   localparam logic [7:0] HDR_FIRST    = 8'hFA;
   localparam logic [7:0] HDR_SECOND   = 8'hFB;
   // The length byte counts the payload plus the two checksum bytes.
   localparam logic [7:0] CHECK_BYTES  = 8'd2;

   typedef enum logic [2:0] {
      PH_HUNT1   = 3'd0,
      PH_HUNT2   = 3'd1,
      PH_LEN     = 3'd2,
      PH_PAYLOAD = 3'd3,
      PH_CHK_HI  = 3'd4,
      PH_CHK_LO  = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_MISMATCH   = 2'd1,
      ST_BAD_HEADER = 2'd2,
      ST_SHORT      = 2'd3
   } frame_status_type;

   typedef enum logic {
      KIND_PAYLOAD = 1'b0,
      KIND_STATUS  = 1'b1
   } result_kind_type;

   typedef struct packed {
      logic [7:0] rx_byte;
   } req_item_type;

   typedef struct packed {
      logic [7:0]       out_byte;
      result_kind_type  result_kind;
      frame_status_type frame_status;
   } rsp_item_type;

   // Contents of the input register as seen by the frame state machine.
   typedef struct packed {
      logic       step;
      logic [7:0] rx_byte;
   } in_stage_type;

endpackage

[rtl/fprc_stream_if.sv]
// ----------------------------------------------------------------------------
// Framed packet receiver stream interface
// Valid/ready channel; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface fprc_stream_if #(
   parameter type payload_type = logic [7:0]
);

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);

endinterface

[rtl/fprc_in_stage.sv]
// ----------------------------------------------------------------------------
// Framed packet receiver input stage
// Registers one received byte and releases it when the result side has room.
// ----------------------------------------------------------------------------
module fprc_in_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  fprc_pkg::req_item_type req_item,
   input  logic                  out_free,
   output fprc_pkg::in_stage_type stage
);
   import fprc_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;

   // The register drains whenever the result register can take a new value.
   assign req_ready = !valid_ff || out_free;
   assign valid_in  = req_ready ? req_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         byte_ff <= req_item.rx_byte;
      end
   end

   assign stage.step    = valid_ff && out_free;
   assign stage.rx_byte = byte_ff;

`ifndef SYNTHESIS
   a_held_byte_stable: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !out_free |=> valid_ff && $stable(byte_ff))
      else $error("input stage lost or changed a held byte");
`endif

endmodule

[rtl/fprc_frame_fsm.sv]
// ----------------------------------------------------------------------------
// Framed packet receiver frame state machine
// Header hunt, length count, word-sum checksum and per-byte result selection.
// ----------------------------------------------------------------------------
module fprc_frame_fsm (
   input  logic                   clock,
   input  logic                   reset,
   input  fprc_pkg::in_stage_type stage,
   output logic                   emit,
   output fprc_pkg::rsp_item_type result
);
   import fprc_pkg::*;

   phase_type   phase_ff,         phase_in;
   logic [7:0]  bytes_left_ff,    bytes_left_in;
   logic [15:0] sum_acc_ff,       sum_acc_in;
   logic [7:0]  held_high_ff,     held_high_in;
   logic        half_word_ff,     half_word_in;
   logic [7:0]  rx_check_high_ff, rx_check_high_in;

   logic [7:0]  b;
   logic [15:0] calc_sum;
   logic [15:0] got_sum;

   assign b = stage.rx_byte;

   // An odd trailing payload byte is folded into the low half of the sum.
   assign calc_sum = sum_acc_ff ^ (half_word_ff ? {8'h00, held_high_ff} : 16'h0000);
   assign got_sum  = {rx_check_high_ff, b};

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_HUNT1;
         bytes_left_ff    <= 8'd0;
         sum_acc_ff       <= 16'd0;
         held_high_ff     <= 8'd0;
         half_word_ff     <= 1'b0;
         rx_check_high_ff <= 8'd0;
      end else begin
         phase_ff         <= phase_in;
         bytes_left_ff    <= bytes_left_in;
         sum_acc_ff       <= sum_acc_in;
         held_high_ff     <= held_high_in;
         half_word_ff     <= half_word_in;
         rx_check_high_ff <= rx_check_high_in;
      end
   end

   always_comb begin
      phase_in            = phase_ff;
      bytes_left_in       = bytes_left_ff;
      sum_acc_in          = sum_acc_ff;
      held_high_in        = held_high_ff;
      half_word_in        = half_word_ff;
      rx_check_high_in    = rx_check_high_ff;
      emit                = 1'b0;
      result.out_byte     = 8'h00;
      result.result_kind  = KIND_PAYLOAD;
      result.frame_status = ST_OK;
      if (stage.step) begin
         case (phase_ff)
            PH_HUNT2: begin
               if (b == HDR_SECOND) begin
                  phase_in = PH_LEN;
               end else begin
                  // A repeated first header byte starts a new header attempt.
                  phase_in            = (b == HDR_FIRST) ? PH_HUNT2 : PH_HUNT1;
                  emit                = 1'b1;
                  result.result_kind  = KIND_STATUS;
                  result.frame_status = ST_BAD_HEADER;
               end
            end
            PH_LEN: begin
               sum_acc_in   = 16'd0;
               held_high_in = 8'd0;
               half_word_in = 1'b0;
               if (b < CHECK_BYTES) begin
                  bytes_left_in       = 8'd0;
                  phase_in            = PH_HUNT1;
                  emit                = 1'b1;
                  result.result_kind  = KIND_STATUS;
                  result.frame_status = ST_SHORT;
               end else begin
                  bytes_left_in = b;
                  phase_in      = (b == CHECK_BYTES) ? PH_CHK_HI : PH_PAYLOAD;
               end
            end
            PH_PAYLOAD: begin
               if (half_word_ff) begin
                  sum_acc_in   = sum_acc_ff + {held_high_ff, b};
                  half_word_in = 1'b0;
               end else begin
                  held_high_in = b;
                  half_word_in = 1'b1;
               end
               bytes_left_in = bytes_left_ff - 8'd1;
               if (bytes_left_in <= CHECK_BYTES) begin
                  phase_in = PH_CHK_HI;
               end
               emit            = 1'b1;
               result.out_byte = b;
            end
            PH_CHK_HI: begin
               rx_check_high_in = b;
               bytes_left_in    = 8'd1;
               phase_in         = PH_CHK_LO;
            end
            PH_CHK_LO: begin
               phase_in            = PH_HUNT1;
               bytes_left_in       = 8'd0;
               sum_acc_in          = 16'd0;
               held_high_in        = 8'd0;
               half_word_in        = 1'b0;
               emit                = 1'b1;
               result.result_kind  = KIND_STATUS;
               result.frame_status = (calc_sum == got_sum) ? ST_OK : ST_MISMATCH;
            end
            default: begin
               phase_in = (b == HDR_FIRST) ? PH_HUNT2 : PH_HUNT1;
            end
         endcase
      end
   end

`ifndef SYNTHESIS
   a_payload_status_zero: assert property (@(posedge clock) disable iff (reset)
      emit && result.result_kind == KIND_PAYLOAD |-> result.frame_status == ST_OK)
      else $error("payload result carries a nonzero status");

   a_status_byte_zero: assert property (@(posedge clock) disable iff (reset)
      emit && result.result_kind == KIND_STATUS |-> result.out_byte == 8'h00)
      else $error("status result carries a nonzero byte");

   a_frame_end_hunts: assert property (@(posedge clock) disable iff (reset)
      stage.step && phase_ff == PH_CHK_LO |=> phase_ff == PH_HUNT1 && !half_word_ff)
      else $error("frame end did not return to header hunt");

   a_hunt_no_half_word: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_HUNT1 || phase_ff == PH_HUNT2 |-> !half_word_ff)
      else $error("pending half word while hunting for a header");
`endif

endmodule

[rtl/fprc_out_stage.sv]
// ----------------------------------------------------------------------------
// Framed packet receiver result register
// Holds one result until the downstream side completes its transfer.
// ----------------------------------------------------------------------------
module fprc_out_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   emit,
   input  fprc_pkg::rsp_item_type result,
   output logic                   out_free,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output fprc_pkg::rsp_item_type rsp_item
);
   import fprc_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   rsp_item_type item_ff;

   // The register can load when it is empty or its value leaves this cycle.
   assign out_free = !valid_ff || rsp_ready;
   assign valid_in = out_free ? emit : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && emit) begin
         item_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_item  = item_ff;

endmodule

[rtl/framed_packet_receiver_checksum.sv]
// ----------------------------------------------------------------------------
// Framed packet receiver with word-sum checksum
// Top level: input register, frame state machine, result register.
// ----------------------------------------------------------------------------
// The receiver takes one serial byte per transfer and sustains one byte per
// clock cycle; each byte passes through the input register, and any result
// that it yields is held in the result register until its transfer. It
// hunts for the header 0xFA 0xFB, reads a length byte that counts payload
// plus two checksum bytes, forwards each payload byte, and closes every
// frame with one status result (ok, checksum mismatch, bad header or length
// below two). The checksum is the sum of the payload as big-endian 16-bit
// words modulo 2^16, with an odd final byte XORed into the low half. Bytes
// other than 0xFA while hunting for the first header byte are dropped
// without a result. Backpressure on the result side holds the input side
// after at most one more byte.
module framed_packet_receiver_checksum (
   input logic           clock,
   input logic           reset,
   fprc_stream_if.sink   req_chan,
   fprc_stream_if.source rsp_chan
);
   import fprc_pkg::*;

   in_stage_type stage;
   logic         out_free;
   logic         emit;
   rsp_item_type result;
   req_item_type req_item;
   rsp_item_type rsp_item;

   assign req_item = req_chan.payload;

   fprc_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .req_item  (req_item),
      .out_free  (out_free),
      .stage     (stage)
   );

   fprc_frame_fsm u_frame_fsm (
      .clock  (clock),
      .reset  (reset),
      .stage  (stage),
      .emit   (emit),
      .result (result)
   );

   fprc_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .emit      (emit),
      .result    (result),
      .out_free  (out_free),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .rsp_item  (rsp_item)
   );

   assign rsp_chan.payload = rsp_item;

endmodule

[bench/tb.sv]
// ----------------------------------------------------------------------------
// Framed packet receiver testbench
// Feeds the receiver directed frames, then randomized frames mixed with
// line noise and broken headers, with random idle cycles on both channels.
// A scoreboard class predicts every payload byte and frame status and checks
// each result transfer against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

   import fprc_pkg::*;

   localparam int ITEM_TARGET = 1050;
   localparam int CYCLE_LIMIT = 400000;
   localparam int MAX_PAYLOAD = 253;
   localparam int MAX_REPORTS = 100;

   // Predicts the receiver's results from the accepted bytes and holds them
   // until the matching result transfer arrives.
   class frame_scoreboard;
      phase_type    rx_phase;
      logic [7:0]   bytes_left;
      logic [15:0]  word_sum;
      logic [7:0]   high_byte;
      logic         half_word;
      logic [7:0]   check_high;
      rsp_item_type expected_q[$];
      int           errors;

      function new();
         rx_phase   = PH_HUNT1;
         bytes_left = '0;
         word_sum   = '0;
         high_byte  = '0;
         half_word  = 1'b0;
         check_high = '0;
         errors     = 0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void push_status(frame_status_type status);
         rsp_item_type item;
         item.out_byte     = 8'h00;
         item.result_kind  = KIND_STATUS;
         item.frame_status = status;
         expected_q.push_back(item);
      endfunction

      function void note_byte(logic [7:0] b);
         rsp_item_type item;
         logic [15:0]  calc;
         case (rx_phase)
            PH_HUNT2: begin
               if (b == HDR_SECOND) begin
                  rx_phase = PH_LEN;
               end else begin
                  // A repeated first header byte may still open a frame.
                  if (b == HDR_FIRST) rx_phase = PH_HUNT2;
                  else rx_phase = PH_HUNT1;
                  push_status(ST_BAD_HEADER);
               end
            end
            PH_LEN: begin
               word_sum  = '0;
               high_byte = '0;
               half_word = 1'b0;
               if (b < CHECK_BYTES) begin
                  bytes_left = '0;
                  rx_phase   = PH_HUNT1;
                  push_status(ST_SHORT);
               end else begin
                  bytes_left = b;
                  if (b == CHECK_BYTES) rx_phase = PH_CHK_HI;
                  else rx_phase = PH_PAYLOAD;
               end
            end
            PH_PAYLOAD: begin
               if (half_word) begin
                  word_sum  = word_sum + {high_byte, b};
                  half_word = 1'b0;
               end else begin
                  high_byte = b;
                  half_word = 1'b1;
               end
               bytes_left = bytes_left - 8'd1;
               if (bytes_left <= CHECK_BYTES) rx_phase = PH_CHK_HI;
               item.out_byte     = b;
               item.result_kind  = KIND_PAYLOAD;
               item.frame_status = ST_OK;
               expected_q.push_back(item);
            end
            PH_CHK_HI: begin
               check_high = b;
               bytes_left = 8'd1;
               rx_phase   = PH_CHK_LO;
            end
            PH_CHK_LO: begin
               calc = word_sum;
               // An odd trailing byte is folded into the low half of the sum.
               if (half_word) calc = calc ^ {8'h00, high_byte};
               if (calc == {check_high, b}) push_status(ST_OK);
               else push_status(ST_MISMATCH);
               rx_phase   = PH_HUNT1;
               bytes_left = '0;
               word_sum   = '0;
               high_byte  = '0;
               half_word  = 1'b0;
            end
            default: begin
               if (b == HDR_FIRST) rx_phase = PH_HUNT2;
               else rx_phase = PH_HUNT1;
            end
         endcase
      endfunction

      function void report(string field, int exp_val, int got_val);
         errors++;
         // Further mismatches are counted but not printed to keep the log short.
         if (errors <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0h, got %0h",
                     $time, field, exp_val, got_val);
      endfunction

      function void check_result(rsp_item_type got);
         rsp_item_type exp;
         if (expected_q.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t: unexpected result, expected none, got %0h/%0d/%0d",
                        $time, got.out_byte, got.result_kind, got.frame_status);
         end else begin
            exp = expected_q.pop_front();
            if (got.out_byte !== exp.out_byte)
               report("out_byte", exp.out_byte, got.out_byte);
            if (got.result_kind !== exp.result_kind)
               report("result_kind", exp.result_kind, got.result_kind);
            if (got.frame_status !== exp.frame_status)
               report("frame_status", exp.frame_status, got.frame_status);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   cycle_count = 0;
   int   sent_count = 0;
   int   big_frames = 0;
   bit   req_idle_on = 1'b1;
   bit   rsp_idle_on = 1'b1;

   frame_scoreboard sb = new();

   fprc_stream_if #(.payload_type(req_item_type)) req_if ();
   fprc_stream_if #(.payload_type(rsp_item_type)) rsp_if ();

   framed_packet_receiver_checksum dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if.sink),
      .rsp_chan (rsp_if.source)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   // Both channels are observed here, on the values that made the transfer.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_if.valid && req_if.ready) sb.note_byte(req_if.payload.rx_byte);
         if (rsp_if.valid && rsp_if.ready) sb.check_result(rsp_if.payload);
      end
   end

   // Drives one byte after a random idle gap and returns at its transfer.
   task automatic send_byte(input logic [7:0] b, input bit counts);
      int gap;
      gap = req_idle_on ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid           <= 1'b1;
      req_if.payload.rx_byte <= b;
      do @(posedge clock); while (!req_if.ready);
      if (counts) sent_count++;
   endtask

   // Drops valid and lets the last transfer be noted before waiting for results.
   task automatic wait_for_results();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // Sends a complete frame with random payload; a corrupted frame carries a
   // checksum with at least one bit flipped.
   task automatic send_frame(input int n, input bit corrupt);
      logic [7:0]  body[$];
      logic [15:0] sum;
      logic [7:0]  length_byte;
      sum = '0;
      for (int i = 0; i < n; i++) body.push_back(8'($urandom_range(0, 255)));
      for (int i = 0; i < n; i += 2) begin
         if (i + 1 < n) sum = sum + {body[i], body[i + 1]};
         else sum = sum ^ {8'h00, body[i]};
      end
      if (corrupt) sum = sum ^ 16'($urandom_range(1, 16'hFFFF));
      length_byte = 8'(n) + CHECK_BYTES;
      send_byte(HDR_FIRST, 1'b1);
      send_byte(HDR_SECOND, 1'b1);
      send_byte(length_byte, 1'b1);
      foreach (body[i]) send_byte(body[i], 1'b1);
      send_byte(sum[15:8], 1'b1);
      send_byte(sum[7:0], 1'b1);
   endtask

   // Noise, broken headers, short lengths and frames that may be cut off early.
   task automatic send_broken();
      int mode;
      int count;
      mode = $urandom_range(0, 3);
      case (mode)
         0: begin
            count = $urandom_range(1, 4);
            repeat (count) send_byte(8'($urandom_range(0, 255)), 1'b0);
         end
         1: begin
            send_byte(HDR_FIRST, 1'b1);
            if ($urandom_range(0, 2) == 0) send_byte(HDR_FIRST, 1'b1);
            else send_byte(8'($urandom_range(0, HDR_FIRST - 1)), 1'b1);
         end
         2: begin
            send_byte(HDR_FIRST, 1'b1);
            send_byte(HDR_SECOND, 1'b1);
            send_byte(8'($urandom_range(0, 1)), 1'b1);
         end
         default: begin
            // Whatever follows the cut is taken as the rest of this frame.
            send_byte(HDR_FIRST, 1'b1);
            send_byte(HDR_SECOND, 1'b1);
            send_byte(8'($urandom_range(3, 20)), 1'b1);
            count = $urandom_range(0, 3);
            repeat (count) send_byte(8'($urandom_range(0, 255)), 1'b1);
         end
      endcase
   endtask

   // Result side: random stall before each transfer, with stall-free runs.
   initial begin
      int stall;
      int taken;
      taken = 0;
      rsp_if.ready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (taken % 64 == 0) rsp_idle_on = ($urandom_range(0, 3) != 0);
         stall = rsp_idle_on ? $urandom_range(0, 7) : 0;
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
         taken++;
      end
   end

   initial begin
      logic [7:0] directed[$];
      int         pick;
      int         n;
      req_if.valid           <= 1'b0;
      req_if.payload.rx_byte <= 8'h00;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Garbage, a bad header, a repeated first header byte followed by a
      // short length, an empty frame, an odd frame and a bad checksum.
      directed = '{8'hFF,
                   HDR_FIRST, 8'h00,
                   HDR_FIRST, HDR_FIRST, HDR_SECOND, 8'h01,
                   HDR_FIRST, HDR_SECOND, 8'h02, 8'h00, 8'h00,
                   HDR_FIRST, HDR_SECOND, 8'h03, 8'hFF, 8'h00, 8'hFF,
                   HDR_FIRST, HDR_SECOND, 8'h04, 8'hFF, 8'hFF, 8'hFF, 8'hFE};
      foreach (directed[i]) send_byte(directed[i], 1'b1);
      wait_for_results();

      while (sent_count < ITEM_TARGET) begin
         req_idle_on = ($urandom_range(0, 3) != 0);
         pick = $urandom_range(0, 99);
         if (pick < 72) begin
            if (big_frames < 3 && $urandom_range(0, 59) == 0) begin
               n = MAX_PAYLOAD;
               big_frames++;
            end else begin
               n = $urandom_range(0, 12);
            end
            send_frame(n, $urandom_range(0, 4) == 0);
         end else if (pick < 96) begin
            send_broken();
         end else begin
            wait_for_results();
         end
      end

      wait_for_results();
      repeat (10) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule

[files.f]
rtl/fprc_pkg.sv
rtl/fprc_stream_if.sv
rtl/fprc_in_stage.sv
rtl/fprc_frame_fsm.sv
rtl/fprc_out_stage.sv
rtl/framed_packet_receiver_checksum.sv
bench/tb.sv
